### src/bkpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkpt_pkg: shared types and constants for the breakpoint table
// Command codes, the lookup record that walks the cell row, and the
// broadcast slot write.
// ----------------------------------------------------------------------------
package bkpt_pkg;

	localparam int DEFAULT_NUM_SLOTS = 4;
	localparam int MAX_SLOTS         = 16;
	localparam int SLOT_IDX_W        = 4;  // covers MAX_SLOTS
	localparam int ADDR_W            = 16;
	localparam int CMD_W             = 2;
	localparam int SLOT_OUT_W        = 2;

	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	localparam cmd_t CMD_CHECK  = 2'd0;
	localparam cmd_t CMD_SET    = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;
	localparam cmd_t CMD_TOGGLE = 2'd3;

	// lookup record, picked up and refined by each cell in turn
	typedef struct packed {
		logic      valid;
		cmd_t      cmd;
		addr_t     addr;
		logic      hit;      // set, enabled and address equal
		logic      m_found;  // first address match, marks ignored
		slot_idx_t m_idx;
		logic      m_set;
		logic      m_en;
		logic      u_found;  // first unset slot
		slot_idx_t u_idx;
		logic      d_found;  // first disabled slot
		slot_idx_t d_idx;
	} walk_rec_t;

	// write broadcast from the control to every cell
	typedef struct packed {
		logic      we;
		slot_idx_t idx;
		addr_t     addr;
		logic      set_mark;
		logic      en_mark;
	} slot_wr_t;

endpackage
`default_nettype wire

### src/bkpt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkpt_cell: one breakpoint slot
// Holds address and marks, folds its own compare into the passing record
// and registers it for the next cell.
// ----------------------------------------------------------------------------
module bkpt_cell #(
	parameter int CELL_IDX = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bkpt_pkg::walk_rec_t   rec_in,
	input  bkpt_pkg::slot_wr_t    wr,
	output bkpt_pkg::walk_rec_t   rec_out
);

	localparam bkpt_pkg::slot_idx_t MY_IDX = bkpt_pkg::SLOT_IDX_W'(CELL_IDX);

	bkpt_pkg::addr_t     addr_q;
	logic                set_q;
	logic                en_q;
	bkpt_pkg::walk_rec_t rec_s1;
	bkpt_pkg::walk_rec_t rec_nxt;
	logic                match;

	assign match = (addr_q == rec_in.addr);

	always_comb begin
		rec_nxt = rec_in;
		if (set_q && en_q && match)
			rec_nxt.hit = 1'b1;
		if (!rec_in.m_found && match) begin
			rec_nxt.m_found = 1'b1;
			rec_nxt.m_idx   = MY_IDX;
			rec_nxt.m_set   = set_q;
			rec_nxt.m_en    = en_q;
		end
		if (!rec_in.u_found && !set_q) begin
			rec_nxt.u_found = 1'b1;
			rec_nxt.u_idx   = MY_IDX;
		end
		if (!rec_in.d_found && !en_q) begin
			rec_nxt.d_found = 1'b1;
			rec_nxt.d_idx   = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			set_q  <= 1'b0;
			en_q   <= 1'b0;
			rec_s1 <= '0;
		end else begin
			rec_s1 <= rec_nxt;
			if (wr.we && wr.idx == MY_IDX) begin
				addr_q <= wr.addr;
				set_q  <= wr.set_mark;
				en_q   <= wr.en_mark;
			end
		end
	end

	assign rec_out = rec_s1;

endmodule
`default_nettype wire

### src/breakpoint_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// breakpoint_table_unit: hardware breakpoint comparator
// Slot table held in a row of cells; a lookup record walks the row.
// ----------------------------------------------------------------------------
// Flow: the accepted record is registered by each cell of the row in turn,
//   then captured as the finished record; result register and slot
//   write-back load on the same edge, once the output is free.
// Only one transaction is in the row at a time; a new one is taken only
//   after the result is loaded and the unit is back in idle.
// Reset: arst_n clears all slot addresses, marks, the victim pointer and
//   the output register at once; no clearing pass.
// ----------------------------------------------------------------------------
module breakpoint_table_unit #(
	parameter int NUM_SLOTS = bkpt_pkg::DEFAULT_NUM_SLOTS
) (
	input  wire        clk,
	input  wire        arst_n,
	// input stream
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // [15:0] address
	input  wire [1:0]  s_tuser,   // [1:0] cmd
	// result stream
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata    // [0] hit, [1] found, [3:2] slot,
	                              // [4] slot_set, [5] slot_enabled, [7:6] zero
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t                    state_q;
	bkpt_pkg::walk_rec_t       chain [NUM_SLOTS+1];
	bkpt_pkg::walk_rec_t       rec_head;
	logic [NUM_SLOTS-1:0]      valid_vec;
	bkpt_pkg::walk_rec_t       end_q;
	bkpt_pkg::slot_idx_t       victim_q;
	bkpt_pkg::slot_wr_t        wr;
	logic                      out_free;
	logic                      finish;
	logic                      in_xfer;
	logic                      adv_victim;
	logic                      r_hit;
	logic                      r_found;
	bkpt_pkg::slot_idx_t       r_idx;
	logic                      r_set;
	logic                      r_en;
	logic                      m_tvalid_q;
	logic [7:0]                m_tdata_q;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == ST_FINISH) && out_free;

	// record entering the row: nothing found yet
	always_comb begin
		rec_head       = '0;
		rec_head.valid = in_xfer;
		rec_head.cmd   = bkpt_pkg::cmd_t'(s_tuser);
		rec_head.addr  = bkpt_pkg::addr_t'(s_tdata);
	end

	assign chain[0] = rec_head;

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		bkpt_cell #(
			.CELL_IDX (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rec_in  (chain[g]),
			.wr      (wr),
			.rec_out (chain[g+1])
		);
		assign valid_vec[g] = chain[g+1].valid;
	end

	// Decide the result and the slot write from the finished record.
	// Set falls back: address match, first unset, first disabled, victim.
	always_comb begin
		r_hit      = 1'b0;
		r_found    = 1'b0;
		r_idx      = '0;
		r_set      = 1'b0;
		r_en       = 1'b0;
		adv_victim = 1'b0;
		wr         = '0;
		wr.addr    = end_q.addr;
		case (end_q.cmd)
			bkpt_pkg::CMD_CHECK: begin
				r_hit = end_q.hit;
			end
			bkpt_pkg::CMD_SET: begin
				r_found = 1'b1;
				r_set   = 1'b1;
				r_en    = 1'b1;
				if (end_q.m_found) begin
					r_idx = end_q.m_idx;
				end else if (end_q.u_found) begin
					r_idx = end_q.u_idx;
				end else if (end_q.d_found) begin
					r_idx = end_q.d_idx;
				end else begin
					r_idx      = victim_q;
					adv_victim = 1'b1;
				end
			end
			bkpt_pkg::CMD_CLEAR: begin
				r_found = end_q.m_found;
				r_idx   = end_q.m_found ? end_q.m_idx : '0;
			end
			bkpt_pkg::CMD_TOGGLE: begin
				r_found = end_q.m_found;
				r_idx   = end_q.m_found ? end_q.m_idx : '0;
				r_set   = end_q.m_found;
				r_en    = end_q.m_found && !end_q.m_en;
			end
			default: begin
				r_hit = 1'b0;
			end
		endcase
		// matched slot keeps its address; rewriting the same value is harmless
		wr.we       = finish && r_found;
		wr.idx      = r_idx;
		wr.set_mark = r_set;
		wr.en_mark  = r_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			end_q      <= '0;
			victim_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (chain[NUM_SLOTS].valid) begin
						end_q   <= chain[NUM_SLOTS];
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, r_en, r_set,
							r_idx[bkpt_pkg::SLOT_OUT_W-1:0], r_found, r_hit};
						if (adv_victim) begin
							if (victim_q == bkpt_pkg::SLOT_IDX_W'(NUM_SLOTS - 1))
								victim_q <= '0;
							else
								victim_q <= victim_q + bkpt_pkg::slot_idx_t'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// at most one lookup record travels the row
	a_one_record: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) <= 1)
		else $error("more than one record in the cell row");

	// an accepted transaction enters the first cell on the next edge
	a_enter_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> chain[1].valid)
		else $error("accepted transaction missing from first cell");

	// finishing always presents a result and frees the input
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> m_tvalid && s_tready)
		else $error("finished lookup gave no result");

	// no input is taken while a record is in the row
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec != '0) |-> !s_tready)
		else $error("input ready while lookup in flight");

endmodule
`default_nettype wire
